>>> sv/tmr_pkg.sv
// ----------------------------------------------------------------------------
// tmr_pkg
// Shared types and constants of the 8-bit timer/counter with compare output.
// ----------------------------------------------------------------------------
`default_nettype none

package tmr_pkg;

    localparam int CNT_W   = 8;
    localparam int DATA_W  = 8;
    localparam int PRESC_W = 10;
    localparam int CFG_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Bus register selects
    localparam logic [1:0] REG_COUNT   = 2'd0;
    localparam logic [1:0] REG_COMPARE = 2'd1;
    localparam logic [1:0] REG_FLAGS   = 2'd2;
    localparam logic [1:0] REG_ENABLES = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_OUT = 2'd2;

    // Waveform modes
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_PHASE    = 2'd1;
    localparam logic [1:0] MODE_CTC      = 2'd2;
    localparam logic [1:0] MODE_FAST_PWM = 2'd3;

    // Clock selects
    localparam logic [2:0] CS_STOP    = 3'd0;
    localparam logic [2:0] CS_DIV1    = 3'd1;
    localparam logic [2:0] CS_DIV8    = 3'd2;
    localparam logic [2:0] CS_DIV64   = 3'd3;
    localparam logic [2:0] CS_DIV256  = 3'd4;
    localparam logic [2:0] CS_DIV1024 = 3'd5;
    localparam logic [2:0] CS_T0_FALL = 3'd6;
    localparam logic [2:0] CS_T0_RISE = 3'd7;

    // Compare output modes
    localparam logic [1:0] COM_OFF    = 2'd0;
    localparam logic [1:0] COM_TOGGLE = 2'd1;
    localparam logic [1:0] COM_CLEAR  = 2'd2;
    localparam logic [1:0] COM_SET    = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        reg_sel;
        logic [DATA_W-1:0] write_data;
        logic              t0_pin;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              oc0_level;
        logic              overflow_irq;
        logic              compare_irq;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     wdata;
    } t_cfg_wr;

endpackage

`default_nettype wire

>>> sv/eight_bit_timer_counter_pwm_unit.sv
// ----------------------------------------------------------------------------
// eight_bit_timer_counter_pwm_unit
// 8-bit timer/counter with prescaler, four waveform modes and compare output.
//
// Each input transaction is either one system clock tick (with the T0 pin
// level) or one bus read or write of the count, compare, flag or enable
// register. Every transaction returns exactly one result: read data, the OC0
// pin level and the two interrupt lines as they stand after the transaction.
// Configuration (wave mode, clock select, compare output mode) is written
// through the i_cfg_* port; the user must write it only while no transaction
// is in flight, as the block itself does not enforce this. A transaction
// accepted at one edge waits in the input register; its result then enters
// the result register when that has room and is offered with o_valid.
// One transaction is accepted per cycle while o_stall is low; the input and
// result registers decouple the two sides, so a result waiting for the
// receiver does not block the next transaction.
// When the receiver asserts i_stall the result holds, one more transaction
// is buffered, and then o_stall rises. Synchronous reset clears the timer
// state, configuration and both valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module eight_bit_timer_counter_pwm_unit
    import tmr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_cmd,
    input  wire logic [1:0]           i_reg_sel,
    input  wire logic [DATA_W-1:0]    i_write_data,
    input  wire logic                 i_t0_pin,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [DATA_W-1:0]         o_read_data,
    output logic                      o_oc0_level,
    output logic                      o_overflow_irq,
    output logic                      o_compare_irq,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    t_item   in_item;
    t_item   core_item;
    t_cfg_wr cfg;
    t_result core_result;
    t_result out_result;
    logic    fire;
    logic    advance;

    always_comb begin
        in_item.cmd        = i_cmd;
        in_item.reg_sel    = i_reg_sel;
        in_item.write_data = i_write_data;
        in_item.t0_pin     = i_t0_pin;
        cfg.we             = i_cfg_we;
        cfg.index          = i_cfg_index;
        cfg.wdata          = i_cfg_wdata;
    end

    tmr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (in_item),
        .i_advance (advance),
        .o_fire    (fire),
        .o_item    (core_item)
    );

    tmr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (core_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    tmr_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_result  (core_result),
        .o_advance (advance),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (out_result)
    );

    assign o_read_data    = out_result.read_data;
    assign o_oc0_level    = out_result.oc0_level;
    assign o_overflow_irq = out_result.overflow_irq;
    assign o_compare_irq  = out_result.compare_irq;

endmodule

`default_nettype wire

>>> sv/tmr_in_stage.sv
// ----------------------------------------------------------------------------
// tmr_in_stage
// Input register: captures one transaction and holds it until the core
// processes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tmr_in_stage
    import tmr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_fire,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_fire  = r_valid && i_advance;
    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/tmr_core.sv
// ----------------------------------------------------------------------------
// tmr_core
// Timer state, prescaler, waveform generation and bus register access.
// Computes the updated state and the result of one transaction in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tmr_core
    import tmr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire t_item   i_item,
    input  wire t_cfg_wr i_cfg,
    output t_result      o_result
);

    logic [1:0]         r_wave_mode,  n_wave_mode;
    logic [2:0]         r_clock_sel,  n_clock_sel;
    logic [1:0]         r_com,        n_com;
    logic [CNT_W-1:0]   r_count,      n_count;
    logic [CNT_W-1:0]   r_cmp_val,    n_cmp_val;
    logic [CNT_W-1:0]   r_cmp_buf,    n_cmp_buf;
    logic [PRESC_W-1:0] r_presc,      n_presc;
    logic               r_ovf_flag,   n_ovf_flag;
    logic               r_cmp_flag,   n_cmp_flag;
    logic [1:0]         r_irq_en,     n_irq_en;
    logic               r_pin,        n_pin;
    logic               r_down,       n_down;
    logic               r_last_t0,    n_last_t0;

    logic              go;
    logic              is_pwm;
    logic              connected;
    logic [DATA_W-1:0] rd;

    always_comb begin
        n_wave_mode = r_wave_mode;
        n_clock_sel = r_clock_sel;
        n_com       = r_com;
        n_count     = r_count;
        n_cmp_val   = r_cmp_val;
        n_cmp_buf   = r_cmp_buf;
        n_presc     = r_presc;
        n_ovf_flag  = r_ovf_flag;
        n_cmp_flag  = r_cmp_flag;
        n_irq_en    = r_irq_en;
        n_pin       = r_pin;
        n_down      = r_down;
        n_last_t0   = r_last_t0;
        go          = 1'b0;
        rd          = '0;
        is_pwm      = (r_wave_mode == MODE_PHASE) || (r_wave_mode == MODE_FAST_PWM);

        if (i_fire) begin
            unique case (i_item.cmd)
                CMD_TICK: begin
                    n_presc = r_presc + 1'b1;
                    unique case (r_clock_sel)
                        CS_STOP:    go = 1'b0;
                        CS_DIV1:    go = 1'b1;
                        CS_DIV8:    go = (n_presc[2:0] == '0);
                        CS_DIV64:   go = (n_presc[5:0] == '0);
                        CS_DIV256:  go = (n_presc[7:0] == '0);
                        CS_DIV1024: go = (n_presc == '0);
                        CS_T0_FALL: go = r_last_t0 && !i_item.t0_pin;
                        CS_T0_RISE: go = !r_last_t0 && i_item.t0_pin;
                        default:    go = 1'b0;
                    endcase
                    n_last_t0 = i_item.t0_pin;

                    if (go) begin
                        unique case (r_wave_mode)
                            MODE_NORMAL, MODE_CTC: begin
                                n_down = 1'b0;
                                if (r_count == CNT_MAX) begin
                                    n_count    = '0;
                                    n_ovf_flag = 1'b1;
                                end else if (r_wave_mode == MODE_CTC &&
                                             r_count == r_cmp_val) begin
                                    n_count = '0;
                                end else begin
                                    n_count = r_count + 1'b1;
                                end
                                if (n_count == r_cmp_val) begin
                                    n_cmp_flag = 1'b1;
                                    unique case (r_com)
                                        COM_TOGGLE: n_pin = !r_pin;
                                        COM_CLEAR:  n_pin = 1'b0;
                                        COM_SET:    n_pin = 1'b1;
                                        default:    n_pin = r_pin;
                                    endcase
                                end
                            end
                            MODE_FAST_PWM: begin
                                n_down = 1'b0;
                                // The match is judged on the count before it advances.
                                if (r_count == r_cmp_val) begin
                                    n_cmp_flag = 1'b1;
                                    if (r_com == COM_CLEAR) begin
                                        n_pin = 1'b0;
                                    end else if (r_com == COM_SET) begin
                                        n_pin = 1'b1;
                                    end
                                end
                                if (r_count == CNT_MAX) begin
                                    n_count    = '0;
                                    n_ovf_flag = 1'b1;
                                    n_cmp_val  = r_cmp_buf;
                                    if (r_com == COM_CLEAR) begin
                                        n_pin = 1'b1;
                                    end else if (r_com == COM_SET) begin
                                        n_pin = 1'b0;
                                    end
                                end else begin
                                    n_count = r_count + 1'b1;
                                end
                            end
                            default: begin
                                // Phase-correct: count up to MAX, then back down to zero.
                                if (r_down) begin
                                    n_count = (r_count == '0) ? CNT_W'(1) : r_count - 1'b1;
                                end else begin
                                    n_count = (r_count == CNT_MAX) ? CNT_MAX - 1'b1
                                                                   : r_count + 1'b1;
                                end
                                if (n_count == CNT_MAX) begin
                                    n_down    = 1'b1;
                                    n_cmp_val = r_cmp_buf;
                                end
                                if (n_count == '0) begin
                                    n_down     = 1'b0;
                                    n_ovf_flag = 1'b1;
                                end
                                if (n_count == n_cmp_val) begin
                                    n_cmp_flag = 1'b1;
                                    if (r_com == COM_CLEAR) begin
                                        n_pin = n_down;
                                    end else if (r_com == COM_SET) begin
                                        n_pin = !n_down;
                                    end
                                end
                            end
                        endcase
                    end
                end
                CMD_WRITE: begin
                    unique case (i_item.reg_sel)
                        REG_COUNT: n_count = CNT_W'(i_item.write_data);
                        REG_COMPARE: begin
                            n_cmp_buf = CNT_W'(i_item.write_data);
                            if (!is_pwm) begin
                                n_cmp_val = CNT_W'(i_item.write_data);
                            end
                        end
                        REG_FLAGS: begin
                            if (i_item.write_data[0]) begin
                                n_ovf_flag = 1'b0;
                            end
                            if (i_item.write_data[1]) begin
                                n_cmp_flag = 1'b0;
                            end
                        end
                        default: n_irq_en = i_item.write_data[1:0];
                    endcase
                end
                CMD_READ: begin
                    unique case (i_item.reg_sel)
                        REG_COUNT:   rd = DATA_W'(r_count);
                        REG_COMPARE: rd = DATA_W'(r_cmp_buf);
                        REG_FLAGS:   rd = DATA_W'({r_cmp_flag, r_ovf_flag});
                        default:     rd = DATA_W'(r_irq_en);
                    endcase
                end
                default: ;
            endcase
        end

        if (i_cfg.we) begin
            unique case (i_cfg.index)
                CFG_WAVE_MODE: begin
                    n_wave_mode = i_cfg.wdata[1:0];
                    // Leaving PWM drops any pending double-buffered compare value in.
                    if (i_cfg.wdata[1:0] == MODE_NORMAL || i_cfg.wdata[1:0] == MODE_CTC) begin
                        n_cmp_val = r_cmp_buf;
                    end
                end
                CFG_CLOCK_SEL:   n_clock_sel = i_cfg.wdata;
                CFG_COMPARE_OUT: n_com       = i_cfg.wdata[1:0];
                default: ;
            endcase
        end
    end

    // Toggle mode has no meaning in the PWM modes, so the pin reads as disconnected.
    assign connected = (r_com != COM_OFF) && !(is_pwm && r_com == COM_TOGGLE);

    always_comb begin
        o_result.read_data    = rd;
        o_result.oc0_level    = connected && n_pin;
        o_result.overflow_irq = n_ovf_flag && n_irq_en[0];
        o_result.compare_irq  = n_cmp_flag && n_irq_en[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode <= MODE_NORMAL;
            r_clock_sel <= CS_STOP;
            r_com       <= COM_OFF;
            r_count     <= '0;
            r_cmp_val   <= '0;
            r_cmp_buf   <= '0;
            r_presc     <= '0;
            r_ovf_flag  <= 1'b0;
            r_cmp_flag  <= 1'b0;
            r_irq_en    <= '0;
            r_pin       <= 1'b0;
            r_down      <= 1'b0;
            r_last_t0   <= 1'b0;
        end else begin
            r_wave_mode <= n_wave_mode;
            r_clock_sel <= n_clock_sel;
            r_com       <= n_com;
            r_count     <= n_count;
            r_cmp_val   <= n_cmp_val;
            r_cmp_buf   <= n_cmp_buf;
            r_presc     <= n_presc;
            r_ovf_flag  <= n_ovf_flag;
            r_cmp_flag  <= n_cmp_flag;
            r_irq_en    <= n_irq_en;
            r_pin       <= n_pin;
            r_down      <= n_down;
            r_last_t0   <= n_last_t0;
        end
    end

endmodule

`default_nettype wire

>>> sv/tmr_out_stage.sv
// ----------------------------------------------------------------------------
// tmr_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tmr_out_stage
    import tmr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire t_result i_result,
    output logic         o_advance,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // The register can take a new result when empty or being emptied this cycle.
    assign o_advance = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

>>> sv/tmr_checker.sv
// ----------------------------------------------------------------------------
// tmr_checker
// Port-level checks of the timer's handshake and pipeline behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module tmr_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall
);

    // A result offered and not taken stays offered.
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("o_valid dropped while stalled");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // With the result register empty the input register always drains.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while result register empty");

    // A transaction accepted while the result register is empty passes the input register and raises o_valid.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !o_valid) |=> ##1 o_valid)
        else $error("accepted transaction produced no result");

endmodule

bind eight_bit_timer_counter_pwm_unit tmr_checker u_tmr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall)
);

`default_nettype wire
